// ===== src/drt_pkg.sv =====
// ----------------------------------------------------------------------------
// drt_pkg
// shared types and codes for the device registry table
// ----------------------------------------------------------------------------
package drt_pkg;

  localparam int IDX_MAX_W = 8;
  localparam int CNT_MAX_W = 7;
  localparam logic [15:0] NO_SHORT = 16'hFFFF;
  localparam logic [4:0] MAX_RESULTS = 5'd16;

  localparam logic [2:0] REQ_JOIN  = 3'd0;
  localparam logic [2:0] REQ_LEAVE = 3'd1;
  localparam logic [2:0] REQ_LOOKL = 3'd2;
  localparam logic [2:0] REQ_LOOKS = 3'd3;
  localparam logic [2:0] REQ_LEARN = 3'd4;
  localparam logic [2:0] REQ_READ  = 3'd5;

  localparam logic [1:0] ST_OK        = 2'd0;
  localparam logic [1:0] ST_NOT_FOUND = 2'd1;
  localparam logic [1:0] ST_FULL      = 2'd2;

  typedef enum logic [2:0] {
    S_IDLE, S_SCAN, S_EXEC, S_LRN, S_LCMP, S_LFIN, S_RISS, S_RDAT
  } state_t;

  typedef struct packed {
    logic                 valid;
    logic                 hit;
    logic [IDX_MAX_W-1:0] hit_idx;
    logic [15:0]          hit_short;
    logic [63:0]          hit_long;
    logic [CNT_MAX_W-1:0] hit_count;
    logic                 free;
    logic [IDX_MAX_W-1:0] free_idx;
  } tok_t;

  typedef struct packed {
    logic                 en;
    logic [IDX_MAX_W-1:0] idx;
    logic                 set_valid;
    logic                 clr_valid;
    logic                 addr_en;
    logic [63:0]          long_addr;
    logic [15:0]          short_addr;
    logic                 cnt_en;
    logic [CNT_MAX_W-1:0] count;
  } cellwr_t;

endpackage

// ===== src/drt_if.sv =====
// ----------------------------------------------------------------------------
// drt request and response channels
// valid/ready channels carrying request and result items
// ----------------------------------------------------------------------------
interface drt_req_if;
  logic        valid;
  logic        ready;
  logic [2:0]  req_type;
  logic [63:0] long_addr;
  logic [15:0] short_addr;
  logic [31:0] cap_word;
  logic [4:0]  read_limit;

  modport source (output valid, req_type, long_addr, short_addr, cap_word, read_limit,
                  input ready);
  modport sink (input valid, req_type, long_addr, short_addr, cap_word, read_limit,
                output ready);
endinterface

interface drt_rsp_if;
  logic        valid;
  logic        ready;
  logic [1:0]  status;
  logic [15:0] found_short;
  logic [63:0] found_long;
  logic [4:0]  cap_total;
  logic [31:0] cap_out;
  logic        last;
  logic [5:0]  active_total;

  modport source (output valid, status, found_short, found_long, cap_total, cap_out,
                  last, active_total, input ready);
  modport sink (input valid, status, found_short, found_long, cap_total, cap_out,
                last, active_total, output ready);
endinterface

// ===== src/drt_cell.sv =====
// ----------------------------------------------------------------------------
// drt_cell
// one table entry; checks the passing search item and hands it on
// ----------------------------------------------------------------------------
module drt_cell #(
  parameter int IDX = 0,
  parameter int CW = 5
) (
  input  logic            clk,
  input  logic            rst,
  input  drt_pkg::cellwr_t wr,
  input  logic [63:0]     key_long,
  input  logic [15:0]     key_short,
  input  logic            by_short,
  input  drt_pkg::tok_t   tok_in,
  output drt_pkg::tok_t   tok_out
);
  import drt_pkg::*;

  logic          valid;
  logic [63:0]   long_addr;
  logic [15:0]   short_addr;
  logic [CW-1:0] count;
  logic          match;
  logic          sel;
  tok_t          tok_next;

  assign sel   = wr.en && (wr.idx == IDX_MAX_W'(IDX));
  assign match = valid && (by_short ? (short_addr == key_short) : (long_addr == key_long));

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (sel) begin
      if (wr.set_valid) valid <= 1'b1;
      if (wr.clr_valid) valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (sel && wr.addr_en) begin
      long_addr  <= wr.long_addr;
      short_addr <= wr.short_addr;
    end
    if (sel && wr.cnt_en) count <= wr.count[CW-1:0];
  end

  always_comb begin
    tok_next = tok_in;
    if (!tok_in.hit && match) begin
      tok_next.hit       = 1'b1;
      tok_next.hit_idx   = IDX_MAX_W'(IDX);
      tok_next.hit_short = short_addr;
      tok_next.hit_long  = long_addr;
      tok_next.hit_count = CNT_MAX_W'(count);
    end
    if (!tok_in.free && !valid) begin
      tok_next.free     = 1'b1;
      tok_next.free_idx = IDX_MAX_W'(IDX);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      tok_out.valid <= 1'b0;
    end else begin
      tok_out.valid <= tok_in.valid;
    end
    tok_out.hit       <= tok_next.hit;
    tok_out.hit_idx   <= tok_next.hit_idx;
    tok_out.hit_short <= tok_next.hit_short;
    tok_out.hit_long  <= tok_next.hit_long;
    tok_out.hit_count <= tok_next.hit_count;
    tok_out.free      <= tok_next.free;
    tok_out.free_idx  <= tok_next.free_idx;
  end

endmodule

// ===== src/device_registry_table.sv =====
// join, leave and lookups give their result once the search item has passed the cell row;
// on a hit, learn first scans the stored capability words for a duplicate, and read
// streams its words one by one; one request is in flight at a time, and req.ready is
// high only in idle; capability memory has one read port and one write port
// the search item walks the cell row one entry per cycle
// reset is synchronous: valid bits and the entry count clear at once, no clearing pass
// ----------------------------------------------------------------------------
// device_registry_table
// associative device table keyed by long address (lookups also by short), with capability word sets
// ----------------------------------------------------------------------------
module device_registry_table #(
  parameter int TABLE_DEPTH = 32,
  parameter int CAPS_PER_ENTRY = 16
) (
  input logic     clk,
  input logic     rst,
  drt_req_if.sink   req,
  drt_rsp_if.source rsp
);
  import drt_pkg::*;

  localparam int IW  = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int CW  = $clog2(CAPS_PER_ENTRY + 1);
  localparam int PW  = (CW > 5) ? CW : 5;
  localparam int VW  = $clog2(TABLE_DEPTH + 1);
  localparam int MD  = TABLE_DEPTH * CAPS_PER_ENTRY;
  localparam int AW  = (MD > 1) ? $clog2(MD) : 1;

  state_t        state, state_next;
  logic          start;
  logic [2:0]    rq_type;
  logic [63:0]   rq_long;
  logic [15:0]   rq_short;
  logic [31:0]   rq_word;
  logic [4:0]    rq_limit;
  tok_t          tk;
  tok_t          chain [TABLE_DEPTH+1];
  cellwr_t       wr;
  logic [PW-1:0] pos, pos_next;
  logic [PW-1:0] rn, rn_next;
  logic          dup, dup_next;
  logic [VW-1:0] vcount, vcount_next;

  logic [31:0]   mem [MD];
  logic [31:0]   mem_rdata;
  logic          mem_we, mem_re;
  logic [AW-1:0] mem_wa, mem_ra, base;
  logic [31:0]   mem_wd;

  logic          o_valid;
  logic [1:0]    o_status;
  logic [15:0]   o_short;
  logic [63:0]   o_long;
  logic [4:0]    o_total;
  logic [31:0]   o_cap;
  logic          o_last;
  logic [5:0]    o_active;
  logic          load_ok, o_load;
  logic [1:0]    n_status;
  logic [15:0]   n_short;
  logic [63:0]   n_long;
  logic [4:0]    n_total;
  logic [31:0]   n_cap;
  logic          n_last;
  logic [CW-1:0] cnt;
  logic [PW-1:0] rd_n;

  assign req.ready = (state == S_IDLE);
  assign load_ok   = !o_valid || rsp.ready;
  assign base      = AW'(tk.hit_idx[IW-1:0]) * AW'(CAPS_PER_ENTRY);
  assign cnt       = tk.hit_count[CW-1:0];

  assign chain[0] = '{valid: start, hit: 1'b0, hit_idx: '0, hit_short: '0, hit_long: '0,
                      hit_count: '0, free: 1'b0, free_idx: '0};

  for (genvar g = 0; g < TABLE_DEPTH; g++) begin : g_cell
    drt_cell #(.IDX(g), .CW(CW)) u_cell (
      .clk(clk), .rst(rst), .wr(wr), .key_long(rq_long), .key_short(rq_short),
      .by_short(rq_type == REQ_LOOKS), .tok_in(chain[g]), .tok_out(chain[g+1])
    );
  end

  always_comb begin
    rd_n = (PW'(cnt) < PW'(rq_limit)) ? PW'(cnt) : PW'(rq_limit);
    if (rd_n > PW'(MAX_RESULTS)) rd_n = PW'(MAX_RESULTS);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= S_IDLE;
      start  <= 1'b0;
      vcount <= '0;
    end else begin
      state  <= state_next;
      start  <= req.valid && req.ready;
      vcount <= vcount_next;
    end
    pos <= pos_next;
    rn  <= rn_next;
    dup <= dup_next;
    if (state == S_SCAN && chain[TABLE_DEPTH].valid) tk <= chain[TABLE_DEPTH];
    if (req.valid && req.ready) begin
      rq_type  <= req.req_type;
      rq_long  <= req.long_addr;
      rq_short <= req.short_addr;
      rq_word  <= req.cap_word;
      rq_limit <= req.read_limit;
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) mem[mem_wa] <= mem_wd;
    if (mem_re) mem_rdata <= mem[mem_ra];
  end

  always_comb begin
    state_next  = state;
    pos_next    = pos;
    rn_next     = rn;
    dup_next    = dup;
    vcount_next = vcount;
    wr          = '0;
    wr.idx      = tk.hit_idx;
    wr.long_addr  = rq_long;
    wr.short_addr = rq_short;
    mem_we = 1'b0;
    mem_wa = base + AW'(cnt);
    mem_wd = rq_word;
    mem_re = 1'b0;
    mem_ra = base + AW'(pos);
    o_load   = 1'b0;
    n_status = ST_NOT_FOUND;
    n_short  = NO_SHORT;
    n_long   = '0;
    n_total  = '0;
    n_cap    = '0;
    n_last   = 1'b1;
    case (state)
      S_IDLE: begin
        if (req.valid) state_next = S_SCAN;
      end
      S_SCAN: begin
        if (chain[TABLE_DEPTH].valid) state_next = S_EXEC;
      end
      S_EXEC: begin
        case (rq_type)
          REQ_JOIN: begin
            if (load_ok) begin
              o_load = 1'b1;
              state_next = S_IDLE;
              if (tk.hit) begin
                wr.en = 1'b1;
                wr.addr_en = 1'b1;
                n_status = ST_OK;
                n_short = rq_short;
                n_total = 5'(cnt);
              end else if (tk.free) begin
                wr.en = 1'b1;
                wr.idx = tk.free_idx;
                wr.addr_en = 1'b1;
                wr.set_valid = 1'b1;
                wr.cnt_en = 1'b1;
                vcount_next = vcount + 1'b1;
                n_status = ST_OK;
                n_short = rq_short;
              end else begin
                n_status = ST_FULL;
              end
            end
          end
          REQ_LEAVE: begin
            if (load_ok) begin
              o_load = 1'b1;
              state_next = S_IDLE;
              if (tk.hit) begin
                wr.en = 1'b1;
                wr.clr_valid = 1'b1;
                vcount_next = vcount - 1'b1;
                n_status = ST_OK;
              end
            end
          end
          REQ_LOOKL, REQ_LOOKS: begin
            if (load_ok) begin
              o_load = 1'b1;
              state_next = S_IDLE;
              if (tk.hit) begin
                n_status = ST_OK;
                n_short = tk.hit_short;
                n_total = 5'(cnt);
                if (rq_type == REQ_LOOKS) n_long = tk.hit_long;
              end
            end
          end
          REQ_LEARN: begin
            if (tk.hit) begin
              pos_next = '0;
              dup_next = 1'b0;
              state_next = S_LRN;
            end else if (load_ok) begin
              o_load = 1'b1;
              state_next = S_IDLE;
            end
          end
          REQ_READ: begin
            if (tk.hit && rd_n != '0) begin
              pos_next = '0;
              rn_next = rd_n;
              state_next = S_RISS;
            end else if (load_ok) begin
              o_load = 1'b1;
              state_next = S_IDLE;
              if (tk.hit) begin
                n_status = ST_OK;
                n_short = tk.hit_short;
              end
            end
          end
          default: begin
            if (load_ok) begin
              o_load = 1'b1;
              state_next = S_IDLE;
            end
          end
        endcase
      end
      S_LRN: begin
        if (pos == PW'(cnt)) begin
          state_next = S_LFIN;
        end else begin
          mem_re = 1'b1;
          state_next = S_LCMP;
        end
      end
      S_LCMP: begin
        if (mem_rdata == rq_word) begin
          dup_next = 1'b1;
          state_next = S_LFIN;
        end else begin
          pos_next = pos + 1'b1;
          state_next = S_LRN;
        end
      end
      S_LFIN: begin
        if (load_ok) begin
          o_load = 1'b1;
          state_next = S_IDLE;
          n_status = ST_OK;
          n_short = tk.hit_short;
          n_total = 5'(cnt);
          if (!dup && PW'(cnt) < PW'(CAPS_PER_ENTRY)) begin
            mem_we = 1'b1;
            wr.en = 1'b1;
            wr.cnt_en = 1'b1;
            wr.count = CNT_MAX_W'(cnt) + 1'b1;
            n_total = 5'(wr.count);
          end
        end
      end
      S_RISS: begin
        mem_re = 1'b1;
        state_next = S_RDAT;
      end
      S_RDAT: begin
        if (load_ok) begin
          o_load = 1'b1;
          n_status = ST_OK;
          n_short = tk.hit_short;
          n_total = 5'(rn);
          n_cap = mem_rdata;
          n_last = (pos + 1'b1 == rn);
          pos_next = pos + 1'b1;
          state_next = n_last ? S_IDLE : S_RISS;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      o_valid <= 1'b0;
    end else if (o_load) begin
      o_valid <= 1'b1;
    end else if (rsp.ready) begin
      o_valid <= 1'b0;
    end
    if (o_load) begin
      o_status <= n_status;
      o_short  <= n_short;
      o_long   <= n_long;
      o_total  <= n_total;
      o_cap    <= n_cap;
      o_last   <= n_last;
      o_active <= 6'(vcount_next);
    end
  end

  assign rsp.valid        = o_valid;
  assign rsp.status       = o_status;
  assign rsp.found_short  = o_short;
  assign rsp.found_long   = o_long;
  assign rsp.cap_total    = o_total;
  assign rsp.cap_out      = o_cap;
  assign rsp.last         = o_last;
  assign rsp.active_total = o_active;

endmodule
